// ----- src/axis_angle_vector_rotation_unit_defines.svh -----
// Assertion macros for the axis-angle vector rotation unit.
`ifndef AXIS_ANGLE_VECTOR_ROTATION_UNIT_DEFINES_SVH
`define AXIS_ANGLE_VECTOR_ROTATION_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define AAVR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("aavr assertion failed (same cycle)");

// Next-cycle implication, disabled in reset.
`define AAVR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("aavr assertion failed (next cycle)");

`endif

// ----- src/aavr_pkg.sv -----
// Shared constants, types and the arctangent table for the rotation unit.
`timescale 1ns / 1ps
package aavr_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int FRACTION_BITS_DEF = 14;

  localparam int DW = 16;  // field width
  localparam int AW = 36;  // angle reduction width (Q30, up to +-8 rad)
  localparam int CW = 34;  // CORDIC x/y/z width

  localparam logic signed [AW-1:0] Q30_PI      = AW'(64'sd3373259426);
  localparam logic signed [AW-1:0] Q30_HALF_PI = AW'(64'sd1686629713);
  localparam logic signed [AW-1:0] Q30_TWO_PI  = AW'(64'sd6746518852);
  localparam logic signed [CW-1:0] Q30_INV_GAIN = CW'(64'sd652032874);
  localparam logic signed [CW:0]   Q30_ONE      = (CW+1)'(64'sd1073741824);

  typedef struct packed {
    logic signed [DW-1:0] vx;
    logic signed [DW-1:0] vy;
    logic signed [DW-1:0] vz;
    logic signed [DW-1:0] ax;
    logic signed [DW-1:0] ay;
    logic signed [DW-1:0] az;
  } aavr_side_t;

  function automatic logic signed [CW-1:0] atan_q30(input int idx);
    logic signed [CW-1:0] v;
    case (idx)
      0:  v = CW'(64'sd843314856);
      1:  v = CW'(64'sd497837829);
      2:  v = CW'(64'sd263043836);
      3:  v = CW'(64'sd133525158);
      4:  v = CW'(64'sd67021686);
      5:  v = CW'(64'sd33543515);
      6:  v = CW'(64'sd16775850);
      7:  v = CW'(64'sd8388437);
      8:  v = CW'(64'sd4194282);
      9:  v = CW'(64'sd2097149);
      10: v = CW'(64'sd1048575);
      11: v = CW'(64'sd524287);
      12: v = CW'(64'sd262143);
      13: v = CW'(64'sd131071);
      14: v = CW'(64'sd65535);
      15: v = CW'(64'sd32767);
      16: v = CW'(64'sd16383);
      17: v = CW'(64'sd8191);
      18: v = CW'(64'sd4095);
      19: v = CW'(64'sd2047);
      20: v = CW'(64'sd1023);
      21: v = CW'(64'sd511);
      22: v = CW'(64'sd255);
      23: v = CW'(64'sd127);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- src/axis_angle_vector_rotation_unit.sv -----
// Stages: the angle front end, one register per CORDIC iteration, then the matrix.
// One transfer per cycle unless the output stalls; every stage is a register.
// A stalled result holds the whole pipeline, input included, through one shared enable.
// Reset (rst_n low, synchronous) clears all valid bits; data registers are not reset.
// No configuration and no state between items.
`timescale 1ns / 1ps
`include "axis_angle_vector_rotation_unit_defines.svh"
module axis_angle_vector_rotation_unit
  import aavr_pkg::*;
#(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [DW-1:0] in_vec_x,
  input  logic signed [DW-1:0] in_vec_y,
  input  logic signed [DW-1:0] in_vec_z,
  input  logic signed [DW-1:0] in_angle,
  input  logic signed [DW-1:0] in_axis_x,
  input  logic signed [DW-1:0] in_axis_y,
  input  logic signed [DW-1:0] in_axis_z,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [DW-1:0] out_rot_x,
  output logic signed [DW-1:0] out_rot_y,
  output logic signed [DW-1:0] out_rot_z
);

  // Pipeline advances unless a finished result is waiting on a stalled output.
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Vector and axis ride along with the angle through the sine/cosine stages.
  aavr_side_t in_side;
  assign in_side = '{vx: in_vec_x, vy: in_vec_y, vz: in_vec_z,
                     ax: in_axis_x, ay: in_axis_y, az: in_axis_z};

  // Angle front end (2 stages)
  logic                 ang_valid;
  logic signed [CW-1:0] ang_z;
  logic                 ang_neg;
  aavr_side_t           ang_side;

  aavr_angle u_angle (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_angle  (in_angle),
    .in_side   (in_side),
    .out_valid (ang_valid),
    .out_z     (ang_z),
    .out_neg   (ang_neg),
    .out_side  (ang_side)
  );

  // CORDIC (CORDIC_STAGES stages): x -> cos, y -> sin, before the fold's sign flip
  logic                 cs_valid;
  logic signed [CW-1:0] cs_x, cs_y;
  logic                 cs_neg;
  aavr_side_t           cs_side;

  aavr_cordic #(
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (ang_valid),
    .in_z      (ang_z),
    .in_neg    (ang_neg),
    .in_side   (ang_side),
    .out_valid (cs_valid),
    .out_x     (cs_x),
    .out_y     (cs_y),
    .out_neg   (cs_neg),
    .out_side  (cs_side)
  );

  // Matrix build and product (7 stages, last one is the output register)
  aavr_matrix #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_matrix (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (cs_valid),
    .in_x      (cs_x),
    .in_y      (cs_y),
    .in_neg    (cs_neg),
    .in_side   (cs_side),
    .out_valid (out_valid),
    .out_rot_x (out_rot_x),
    .out_rot_y (out_rot_y),
    .out_rot_z (out_rot_z)
  );

  // A held result must back-pressure the input.
  `AAVR_ASSERT_NOW(a_stall_reaches_input, clk, rst_n, out_valid && out_stall, in_stall)
  // While the result is held, the middle of the pipeline must freeze too.
  `AAVR_ASSERT_NEXT(a_pipe_frozen, clk, rst_n, out_valid && out_stall, $stable(cs_valid) && $stable(cs_x) && $stable(cs_y))
  // The folded angle entering the CORDIC stays within +-pi/2.
  `AAVR_ASSERT_NOW(a_fold_range, clk, rst_n, ang_valid, (AW'(ang_z) <= Q30_HALF_PI) && (AW'(ang_z) >= -Q30_HALF_PI))

endmodule

// ----- src/aavr_angle.sv -----
// Angle front end: Q12 to Q30, 2*pi reduction, fold into +-pi/2.
`timescale 1ns / 1ps
module aavr_angle
  import aavr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [DW-1:0] in_angle,
  input  aavr_side_t           in_side,
  output logic                 out_valid,
  output logic signed [CW-1:0] out_z,
  output logic                 out_neg,
  output aavr_side_t           out_side
);

  logic signed [AW-1:0] th0;
  logic signed [AW-1:0] th1_nxt, th1_r;
  logic signed [AW-1:0] z_full;
  logic                 neg_nxt, neg_r;
  logic signed [CW-1:0] z_r;
  logic [1:0]           vld_r;
  aavr_side_t           side1_r, side2_r;

  // stage 1: scale and one 2*pi correction
  always_comb begin
    th0 = AW'(in_angle) <<< 18;
    if (th0 > Q30_PI) th1_nxt = th0 - Q30_TWO_PI;
    else if (th0 < -Q30_PI) th1_nxt = th0 + Q30_TWO_PI;
    else th1_nxt = th0;
  end

  // stage 2: fold, remember the sign flip
  always_comb begin
    neg_nxt = 1'b0;
    z_full  = th1_r;
    if (th1_r > Q30_HALF_PI) begin
      z_full  = th1_r - Q30_PI;
      neg_nxt = 1'b1;
    end else if (th1_r < -Q30_HALF_PI) begin
      z_full  = th1_r + Q30_PI;
      neg_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      th1_r   <= th1_nxt;
      side1_r <= in_side;
      z_r     <= CW'(z_full);
      neg_r   <= neg_nxt;
      side2_r <= side1_r;
    end
  end

  assign out_valid = vld_r[1];
  assign out_z     = z_r;
  assign out_neg   = neg_r;
  assign out_side  = side2_r;

endmodule

// ----- src/aavr_cordic.sv -----
// Pipelined rotation-mode CORDIC, one iteration per register stage.
`timescale 1ns / 1ps
module aavr_cordic
  import aavr_pkg::*;
#(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [CW-1:0] in_z,
  input  logic                 in_neg,
  input  aavr_side_t           in_side,
  output logic                 out_valid,
  output logic signed [CW-1:0] out_x,
  output logic signed [CW-1:0] out_y,
  output logic                 out_neg,
  output aavr_side_t           out_side
);

  logic signed [CW-1:0]     x_r [CORDIC_STAGES];
  logic signed [CW-1:0]     y_r [CORDIC_STAGES];
  logic signed [CW-1:0]     z_r [CORDIC_STAGES];
  logic [CORDIC_STAGES-1:0] vld_r;
  logic [CORDIC_STAGES-1:0] neg_r;
  aavr_side_t               side_r [CORDIC_STAGES];

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    logic signed [CW-1:0] xi, yi, zi;
    logic signed [CW-1:0] x_nxt, y_nxt, z_nxt;
    logic                 vi, ni;
    aavr_side_t           si;

    if (i == 0) begin : g_first
      assign xi = Q30_INV_GAIN;
      assign yi = '0;
      assign zi = in_z;
      assign vi = in_valid;
      assign ni = in_neg;
      assign si = in_side;
    end else begin : g_next
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign zi = z_r[i-1];
      assign vi = vld_r[i-1];
      assign ni = neg_r[i-1];
      assign si = side_r[i-1];
    end

    // rotate toward zero residual angle; ties go positive
    always_comb begin
      if (!zi[CW-1]) begin
        x_nxt = xi - (yi >>> i);
        y_nxt = yi + (xi >>> i);
        z_nxt = zi - atan_q30(i);
      end else begin
        x_nxt = xi + (yi >>> i);
        y_nxt = yi - (xi >>> i);
        z_nxt = zi + atan_q30(i);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i]    <= x_nxt;
        y_r[i]    <= y_nxt;
        z_r[i]    <= z_nxt;
        neg_r[i]  <= ni;
        side_r[i] <= si;
      end
    end
  end

  assign out_valid = vld_r[CORDIC_STAGES-1];
  assign out_x     = x_r[CORDIC_STAGES-1];
  assign out_y     = y_r[CORDIC_STAGES-1];
  assign out_neg   = neg_r[CORDIC_STAGES-1];
  assign out_side  = side_r[CORDIC_STAGES-1];

endmodule

// ----- src/aavr_matrix.sv -----
// Rotation matrix build and matrix-vector product, with rounding and saturation.
`timescale 1ns / 1ps
module aavr_matrix
  import aavr_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [CW-1:0] in_x,
  input  logic signed [CW-1:0] in_y,
  input  logic                 in_neg,
  input  aavr_side_t           in_side,
  output logic                 out_valid,
  output logic signed [DW-1:0] out_rot_x,
  output logic signed [DW-1:0] out_rot_y,
  output logic signed [DW-1:0] out_rot_z
);

  localparam int F   = FRACTION_BITS;
  localparam int AAW = 2 * DW;          // axis*axis
  localparam int PW  = AAW + CW + 1;    // axis*axis*(1-c)
  localparam int QW  = DW + CW;         // axis*s
  localparam int RA  = 62 - 2 * F;
  localparam int RB  = 47 - F;
  localparam int RM  = (RA > RB) ? RA : RB;
  localparam int RW  = ((RM > 32) ? RM : 32) + 2;  // matrix entry
  localparam int MW  = DW + RW;         // v*R
  localparam int SW  = MW + 2;          // row sum

  localparam logic signed [PW-1:0] HALF_P = PW'(1) <<< (2 * F - 1);
  localparam logic signed [QW-1:0] HALF_Q = QW'(1) <<< (F - 1);
  localparam logic signed [SW-1:0] HALF_O = SW'(1) <<< 29;
  localparam logic signed [SW-1:0] SAT_HI = SW'(32767);
  localparam logic signed [SW-1:0] SAT_LO = -SW'(32768);

  logic [6:0] vld_r;

  // stage 1: sign-corrected sin/cos, 1-cos, axis outer products
  logic signed [CW-1:0]  s1_nxt, c1_nxt, s1_r, c1_r;
  logic signed [CW:0]    cm1_r;
  logic signed [AAW-1:0] aa1_r [6];
  aavr_side_t            side1_r;

  assign s1_nxt = in_neg ? -in_y : in_y;
  assign c1_nxt = in_neg ? -in_x : in_x;

  // stage 2: products
  logic signed [PW-1:0] p2_r [6];
  logic signed [QW-1:0] q2_r [3];
  logic signed [CW-1:0] c2_r;
  logic signed [DW-1:0] v2_r [3];

  // stage 3: rounded terms
  logic signed [RW-1:0] rr3_r [6];
  logic signed [RW-1:0] sa3_r [3];
  logic signed [RW-1:0] c3_r;
  logic signed [DW-1:0] v3_r [3];

  // stage 4: matrix
  logic signed [RW-1:0] m4_r [9];
  logic signed [DW-1:0] v4_r [3];

  // stage 5: element products, stage 6: row sums, stage 7: output
  logic signed [MW-1:0] pr5_r [9];
  logic signed [SW-1:0] acc6_r [3];
  logic signed [SW-1:0] rnd [3];
  logic signed [DW-1:0] o_nxt [3];
  logic signed [DW-1:0] o7_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd[i] = (acc6_r[i] + HALF_O) >>> 30;
      if (rnd[i] > SAT_HI) o_nxt[i] = DW'(SAT_HI);
      else if (rnd[i] < SAT_LO) o_nxt[i] = DW'(SAT_LO);
      else o_nxt[i] = DW'(rnd[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[5:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1
      s1_r    <= s1_nxt;
      c1_r    <= c1_nxt;
      cm1_r   <= Q30_ONE - (CW+1)'(c1_nxt);
      aa1_r[0] <= AAW'(in_side.ax) * AAW'(in_side.ax);
      aa1_r[1] <= AAW'(in_side.ax) * AAW'(in_side.ay);
      aa1_r[2] <= AAW'(in_side.ax) * AAW'(in_side.az);
      aa1_r[3] <= AAW'(in_side.ay) * AAW'(in_side.ay);
      aa1_r[4] <= AAW'(in_side.ay) * AAW'(in_side.az);
      aa1_r[5] <= AAW'(in_side.az) * AAW'(in_side.az);
      side1_r <= in_side;
      // stage 2
      for (int k = 0; k < 6; k++) p2_r[k] <= PW'(aa1_r[k]) * PW'(cm1_r);
      q2_r[0] <= QW'(side1_r.ax) * QW'(s1_r);
      q2_r[1] <= QW'(side1_r.ay) * QW'(s1_r);
      q2_r[2] <= QW'(side1_r.az) * QW'(s1_r);
      c2_r    <= c1_r;
      v2_r[0] <= side1_r.vx;
      v2_r[1] <= side1_r.vy;
      v2_r[2] <= side1_r.vz;
      // stage 3
      for (int k = 0; k < 6; k++) rr3_r[k] <= RW'((p2_r[k] + HALF_P) >>> (2 * F));
      for (int k = 0; k < 3; k++) sa3_r[k] <= RW'((q2_r[k] + HALF_Q) >>> F);
      c3_r <= RW'(c2_r);
      v3_r <= v2_r;
      // stage 4
      m4_r[0] <= rr3_r[0] + c3_r;
      m4_r[1] <= rr3_r[1] - sa3_r[2];
      m4_r[2] <= rr3_r[2] + sa3_r[1];
      m4_r[3] <= rr3_r[1] + sa3_r[2];
      m4_r[4] <= rr3_r[3] + c3_r;
      m4_r[5] <= rr3_r[4] - sa3_r[0];
      m4_r[6] <= rr3_r[2] - sa3_r[1];
      m4_r[7] <= rr3_r[4] + sa3_r[0];
      m4_r[8] <= rr3_r[5] + c3_r;
      v4_r    <= v3_r;
      // stage 5
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pr5_r[3*i+j] <= MW'(v4_r[j]) * MW'(m4_r[3*i+j]);
        end
      end
      // stage 6
      for (int i = 0; i < 3; i++) begin
        acc6_r[i] <= SW'(pr5_r[3*i]) + SW'(pr5_r[3*i+1]) + SW'(pr5_r[3*i+2]);
      end
      // stage 7
      o7_r <= o_nxt;
    end
  end

  assign out_valid = vld_r[6];
  assign out_rot_x = o7_r[0];
  assign out_rot_y = o7_r[1];
  assign out_rot_z = o7_r[2];

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the axis-angle vector rotation unit.
`timescale 1ns / 1ps
module testbench
  import aavr_pkg::*;
;

  localparam int STAGES = CORDIC_STAGES_DEF;
  localparam int FRAC = FRACTION_BITS_DEF;
  localparam int LATENCY = 9 + STAGES;
  localparam longint CYCLE_LIMIT = 400000;

  localparam longint PI_Q30 = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint TWO_PI_Q30 = 64'sd6746518852;
  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam longint INV_GAIN_Q30 = 64'sd652032874;

  // Extremes of the accepted ranges.
  localparam int ANGLE_MAX = 25736;
  localparam int AXIS_ONE = 16384;

  typedef struct {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [DW-1:0] z;
  } rot_vec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [DW-1:0] in_vec_x = '0;
  logic signed [DW-1:0] in_vec_y = '0;
  logic signed [DW-1:0] in_vec_z = '0;
  logic signed [DW-1:0] in_angle = '0;
  logic signed [DW-1:0] in_axis_x = '0;
  logic signed [DW-1:0] in_axis_y = '0;
  logic signed [DW-1:0] in_axis_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [DW-1:0] out_rot_x;
  logic signed [DW-1:0] out_rot_y;
  logic signed [DW-1:0] out_rot_z;

  rot_vec_t expected_rotations[$];
  int unsigned error_count = 0;
  longint cycle_count = 0;
  // Receiver idling on/off; the idle-free phase clears it.
  bit stall_enable = 1'b1;
  bit gaps_enable = 1'b1;

  int atan_table[24] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515, 16775850,
    8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071, 65535, 32767,
    16383, 8191, 4095, 2047, 1023, 511, 255, 127
  };

  axis_angle_vector_rotation_unit dut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic longint floor_sh(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_sh(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [DW-1:0] clamp16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return DW'(v);
  endfunction

  // Rodrigues rotation with CORDIC sine/cosine, bit-exact fixed point.
  function automatic rot_vec_t rotate_vector(logic signed [DW-1:0] vx, vy, vz,
                                             logic signed [DW-1:0] ang,
                                             logic signed [DW-1:0] ax, ay, az);
    longint th, cx, sy, nx, s, c, cm, acc;
    longint v[3], a[3], sa[3], r[3][3];
    bit neg;
    rot_vec_t res;
    th = longint'(ang) * 262144;
    cx = INV_GAIN_Q30;
    sy = 0;
    neg = 1'b0;
    v = '{longint'(vx), longint'(vy), longint'(vz)};
    a = '{longint'(ax), longint'(ay), longint'(az)};
    if (th > PI_Q30) th -= TWO_PI_Q30;
    else if (th < -PI_Q30) th += TWO_PI_Q30;
    if (th > HALF_PI_Q30) begin
      th -= PI_Q30;
      neg = 1'b1;
    end else if (th < -HALF_PI_Q30) begin
      th += PI_Q30;
      neg = 1'b1;
    end
    for (int i = 0; i < STAGES && i < 24; i++) begin
      if (th >= 0) begin
        nx = cx - floor_sh(sy, i);
        sy = sy + floor_sh(cx, i);
        th -= atan_table[i];
      end else begin
        nx = cx + floor_sh(sy, i);
        sy = sy - floor_sh(cx, i);
        th += atan_table[i];
      end
      cx = nx;
    end
    s = neg ? -sy : sy;
    c = neg ? -cx : cx;
    cm = ONE_Q30 - c;
    for (int i = 0; i < 3; i++) sa[i] = round_sh(a[i] * s, FRAC);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) r[i][j] = round_sh(a[i] * a[j] * cm, 2 * FRAC);
    r[0][0] += c;
    r[1][1] += c;
    r[2][2] += c;
    r[0][1] -= sa[2];
    r[0][2] += sa[1];
    r[1][0] += sa[2];
    r[1][2] -= sa[0];
    r[2][0] -= sa[1];
    r[2][1] += sa[0];
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += v[j] * r[i][j];
      case (i)
        0: res.x = clamp16(round_sh(acc, 30));
        1: res.y = clamp16(round_sh(acc, 30));
        default: res.z = clamp16(round_sh(acc, 30));
      endcase
    end
    return res;
  endfunction

  function automatic int gap_len();
    if (!gaps_enable) return 0;
    if ($urandom_range(0, 99) < 60) return 0;
    if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(string what, logic signed [DW-1:0] got, exp_v);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, exp_v,
             cycle_count);
    error_count++;
  endtask

  // Send one vector; valid stays high across back-to-back transfers.
  task automatic send_rotation(logic signed [DW-1:0] vx, vy, vz, ang, ax, ay, az);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_vec_x <= vx;
    in_vec_y <= vy;
    in_vec_z <= vz;
    in_angle <= ang;
    in_axis_x <= ax;
    in_axis_y <= ay;
    in_axis_z <= az;
    expected_rotations.push_back(rotate_vector(vx, vy, vz, ang, ax, ay, az));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic finish_sending();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [DW-1:0] any16();
    return DW'($urandom());
  endfunction

  function automatic logic signed [DW-1:0] rand_angle();
    return DW'($urandom_range(0, 2 * ANGLE_MAX)) - DW'(ANGLE_MAX);
  endfunction

  // Random axis component, drawn uniformly within +-1.0.
  function automatic logic signed [DW-1:0] rand_axis_comp();
    return DW'($urandom_range(0, 2 * AXIS_ONE)) - DW'(AXIS_ONE);
  endfunction

  task automatic test_directed();
    logic signed [DW-1:0] one, mone;
    one = DW'(AXIS_ONE);
    mone = -DW'(AXIS_ONE);
    // Identity at zero angle, extremes of vector.
    send_rotation(16'sh7fff, 16'sh8000, 16'sh4000, 0, 0, 0, one);
    // A quarter turn about z, a half turn about x and a negative quarter turn about y.
    send_rotation(16'sh4000, 0, 0, 16'sd6434, 0, 0, one);
    send_rotation(0, 16'sh4000, 0, 16'sd12868, one, 0, 0);
    send_rotation(0, 0, 16'sh4000, -16'sd6434, 0, one, 0);
    // Angle extremes and full 16-bit range beyond two pi.
    send_rotation(16'sh2000, 16'sh1000, 16'sh0800, DW'(ANGLE_MAX), 0, 0, one);
    send_rotation(16'sh2000, 16'sh1000, 16'sh0800, -DW'(ANGLE_MAX), 0, 0, mone);
    send_rotation(16'sh3000, -16'sh3000, 16'sh1000, 16'sh7fff, one, 0, 0);
    send_rotation(16'sh3000, -16'sh3000, 16'sh1000, 16'sh8000, 0, mone, 0);
    // Output overflow: large vector rotated toward a corner saturates.
    send_rotation(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sd3217, 0, 0, one);
    send_rotation(16'sh8000, 16'sh8000, 16'sh8000, -16'sd3217, one, 0, 0);
    // Axis not of unit length, and full-range raw axis values.
    send_rotation(16'sh4000, 16'sh2000, -16'sh2000, 16'sd5000, one, one, one);
    send_rotation(16'sh1234, -16'sh4321, 16'sh0fff, -16'sd9000, 0, 0, 0);
    send_rotation(16'sh0100, 16'sh0200, 16'sh0300, 16'sd7000, 16'sh7fff, 16'sh8000,
                  16'sh7fff);
    send_rotation(16'sh8000, 16'sh7fff, 16'sh0001, 16'sh0001, 16'sh8000, 16'sh8000,
                  16'sh8000);
    send_rotation(-16'sh0001, 16'sh0000, 16'sh5555, 16'shffff, 16'shaaaa, 16'sh5555,
                  16'shffff);
    finish_sending();
  endtask

  task automatic test_random(int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) < 7)
        send_rotation(any16(), any16(), any16(), rand_angle(), rand_axis_comp(),
                      rand_axis_comp(), rand_axis_comp());
      else
        send_rotation(any16(), any16(), any16(), any16(), any16(), any16(), any16());
    end
    finish_sending();
  endtask

  // Full-rate burst with no idling on either side.
  task automatic test_back_to_back(int count);
    gaps_enable = 1'b0;
    stall_enable = 1'b0;
    for (int n = 0; n < count; n++)
      send_rotation(any16(), any16(), any16(), rand_angle(), rand_axis_comp(),
                    rand_axis_comp(), rand_axis_comp());
    finish_sending();
    gaps_enable = 1'b1;
    stall_enable = 1'b1;
  endtask

  // Receiver stall pattern; changes only at clock edges.
  initial begin
    int hold;
    forever begin
      @(posedge clk);
      if (hold > 0) hold--;
      else if (!stall_enable) out_stall <= 1'b0;
      else begin
        hold = gap_len();
        out_stall <= (hold > 0);
      end
    end
  end

  // Result checker.
  initial begin
    rot_vec_t exp_r;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (expected_rotations.size() == 0) begin
          report_mismatch("unexpected result", out_rot_x, '0);
        end else begin
          exp_r = expected_rotations.pop_front();
          if (out_rot_x !== exp_r.x) report_mismatch("rot_x", out_rot_x, exp_r.x);
          if (out_rot_y !== exp_r.y) report_mismatch("rot_y", out_rot_y, exp_r.y);
          if (out_rot_z !== exp_r.z) report_mismatch("rot_z", out_rot_z, exp_r.z);
        end
      end
    end
  end

  // Watchdog.
  initial begin
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("axis_angle_vector_rotation_unit regression: fail");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(500);
    test_back_to_back(60);
    test_random(90);
    while (expected_rotations.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (error_count == 0) $display("axis_angle_vector_rotation_unit regression: pass");
    else $display("axis_angle_vector_rotation_unit regression: fail");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/aavr_pkg.sv
src/aavr_angle.sv
src/aavr_cordic.sv
src/aavr_matrix.sv
src/axis_angle_vector_rotation_unit.sv
dv/testbench.sv
